@@ rtl/xtt_pkg.sv @@
// ----------------------------------------------------------------------------
// xtt_pkg
// Shared types and constants of the XML tag and attribute tokenizer.
// ----------------------------------------------------------------------------
package xtt_pkg;

  // character codes the scanner looks for
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  // byte classes
  localparam logic [2:0] CLS_TEXT  = 3'd0;
  localparam logic [2:0] CLS_ELEM  = 3'd1;
  localparam logic [2:0] CLS_ANAME = 3'd2;
  localparam logic [2:0] CLS_AVAL  = 3'd3;
  localparam logic [2:0] CLS_MARK  = 3'd4;
  localparam logic [2:0] CLS_BODY  = 3'd5;

  // tag kinds
  localparam logic [2:0] KIND_START = 3'd0;
  localparam logic [2:0] KIND_END   = 3'd1;
  localparam logic [2:0] KIND_SELF  = 3'd2;
  localparam logic [2:0] KIND_DECL  = 3'd3;
  localparam logic [2:0] KIND_COMM  = 3'd4;

  // error codes
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_EMPTY_NAME = 3'd1;
  localparam logic [2:0] ERR_NO_EQUALS  = 3'd2;
  localparam logic [2:0] ERR_QUOTE_OPEN = 3'd3;
  localparam logic [2:0] ERR_NO_VALUE   = 3'd4;
  localparam logic [2:0] ERR_EOF_IN_TAG = 3'd5;

  // character flags produced by the front classifier
  typedef struct packed {
    logic lt;
    logic gt;
    logic slash;
    logic eq;
    logic qmark;
    logic bang;
    logic ws;
    logic dquote;
    logic squote;
  } char_flags_t;

  // one classified item as it travels through the queue
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    char_flags_t flags;
  } tok_item_t;

endpackage

@@ rtl/xtt_front.sv @@
// ----------------------------------------------------------------------------
// xtt_front
// Input side: takes stream bytes and decodes the characters the scanner needs.
// ----------------------------------------------------------------------------
module xtt_front import xtt_pkg::*; (
  input  logic       s_valid_i,
  input  logic [7:0] s_data_i,
  input  logic       s_last_i,
  output logic       s_ready_o,
  input  logic       q_full_i,
  output logic       push_o,
  output tok_item_t  item_o
);

  // accept whenever the queue has room
  assign s_ready_o = ~q_full_i;
  assign push_o    = s_valid_i & ~q_full_i;

  // character decode
  always_comb begin
    item_o.data         = s_data_i;
    item_o.last         = s_last_i;
    item_o.flags.lt     = (s_data_i == CH_LT);
    item_o.flags.gt     = (s_data_i == CH_GT);
    item_o.flags.slash  = (s_data_i == CH_SLASH);
    item_o.flags.eq     = (s_data_i == CH_EQ);
    item_o.flags.qmark  = (s_data_i == CH_QMARK);
    item_o.flags.bang   = (s_data_i == CH_BANG);
    item_o.flags.dquote = (s_data_i == CH_DQUOTE);
    item_o.flags.squote = (s_data_i == CH_SQUOTE);
    item_o.flags.ws     = (s_data_i == CH_SPACE) ||
                          ((s_data_i >= CH_TAB) && (s_data_i <= CH_CR));
  end

endmodule

@@ rtl/xtt_queue.sv @@
// ----------------------------------------------------------------------------
// xtt_queue
// Short FIFO of classified items between the front and the scanner.
// ----------------------------------------------------------------------------
module xtt_queue import xtt_pkg::*; #(
  parameter int Depth = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  tok_item_t item_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output tok_item_t item_o
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LastIdx = AW'(Depth - 1);
  localparam logic [CW-1:0] Full    = CW'(Depth);

  tok_item_t     mem_q [Depth];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;

  assign full_o  = (count_q == Full);
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

@@ rtl/xtt_back.sv @@
// ----------------------------------------------------------------------------
// xtt_back
// Scanner state machine: labels each byte and drives the output register.
// ----------------------------------------------------------------------------
module xtt_back import xtt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  tok_item_t  item_i,
  output logic       pop_o,
  output logic       m_valid_o,
  input  logic       m_ready_i,
  output logic [7:0] out_byte_o,
  output logic [2:0] byte_class_o,
  output logic       token_first_o,
  output logic       tag_done_o,
  output logic [2:0] tag_kind_o,
  output logic [2:0] error_code_o
);

  typedef enum logic [3:0] {
    ST_TEXT_IDLE  = 4'd0,
    ST_TEXT_RUN   = 4'd1,
    ST_TAG_OPEN   = 4'd2,
    ST_END_NAME   = 4'd3,
    ST_ELEM_NAME  = 4'd4,
    ST_BODY       = 4'd5,
    ST_ATTR_WS    = 4'd6,
    ST_ATTR_SLASH = 4'd7,
    ST_ATTR_NAME  = 4'd8,
    ST_ATTR_SEEK  = 4'd9,
    ST_VAL_FIRST  = 4'd10,
    ST_VAL        = 4'd11
  } state_e;

  state_e      state_q, state_d;
  logic        quote_single_q, quote_single_d;
  logic        equals_seen_q, equals_seen_d;
  logic [2:0]  tag_kind_q, tag_kind_d;
  logic [2:0]  sticky_q, sticky_d;

  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic [2:0]  out_class_q, out_kind_q, out_err_q;
  logic        out_first_q, out_done_q;

  logic        quote_match;
  logic [2:0]  cls, kind, err;
  logic        first, done;
  char_flags_t f;

  assign f     = item_i.flags;
  assign pop_o = q_valid_i & (~out_valid_q | m_ready_i);

  // next state and result of the byte at the queue head
  always_comb begin
    state_d        = state_q;
    quote_single_d = quote_single_q;
    equals_seen_d  = equals_seen_q;
    tag_kind_d     = tag_kind_q;
    sticky_d       = sticky_q;
    cls            = CLS_MARK;
    first          = 1'b0;
    done           = 1'b0;
    kind           = KIND_START;
    err            = ERR_NONE;
    quote_match    = quote_single_q ? f.squote : f.dquote;

    if (sticky_q != ERR_NONE) begin
      err = sticky_q;
    end else begin
      unique case (state_q)
        ST_TAG_OPEN: begin
          if (f.slash) begin
            tag_kind_d = KIND_END;
            state_d    = ST_END_NAME;
          end else if (f.qmark) begin
            tag_kind_d = KIND_DECL;
            state_d    = ST_BODY;
          end else if (f.bang) begin
            tag_kind_d = KIND_COMM;
            state_d    = ST_BODY;
          end else if (f.gt || f.ws) begin
            err = ERR_EMPTY_NAME;
          end else begin
            tag_kind_d = KIND_START;
            cls        = CLS_ELEM;
            first      = 1'b1;
            state_d    = ST_ELEM_NAME;
          end
        end
        ST_END_NAME: begin
          if (f.gt || f.slash || f.ws) begin
            err = ERR_EMPTY_NAME;
          end else begin
            cls     = CLS_ELEM;
            first   = 1'b1;
            state_d = ST_ELEM_NAME;
          end
        end
        ST_ELEM_NAME: begin
          if (f.gt) begin
            done = 1'b1;
            kind = tag_kind_q;
          end else if (f.slash) begin
            state_d = ST_ATTR_SLASH;
          end else if (f.ws) begin
            state_d = ST_ATTR_WS;
          end else begin
            cls = CLS_ELEM;
          end
        end
        ST_BODY: begin
          if (f.gt) begin
            done = 1'b1;
            kind = tag_kind_q;
          end else begin
            cls = CLS_BODY;
          end
        end
        ST_ATTR_WS: begin
          if (f.gt) begin
            done = 1'b1;
            kind = tag_kind_q;
          end else if (f.slash) begin
            state_d = ST_ATTR_SLASH;
          end else if (!f.ws) begin
            cls           = CLS_ANAME;
            first         = 1'b1;
            equals_seen_d = 1'b0;
            state_d       = ST_ATTR_NAME;
          end
        end
        ST_ATTR_SLASH: begin
          equals_seen_d = 1'b0;
          if (f.gt) begin
            done = 1'b1;
            kind = (tag_kind_q == KIND_START) ? KIND_SELF : tag_kind_q;
          end else if (f.ws) begin
            state_d = ST_ATTR_SEEK;
          end else if (f.eq) begin
            equals_seen_d = 1'b1;
            state_d       = ST_ATTR_SEEK;
          end else begin
            cls     = CLS_ANAME;
            first   = 1'b1;
            state_d = ST_ATTR_NAME;
          end
        end
        ST_ATTR_NAME: begin
          if (f.gt) begin
            err = ERR_NO_VALUE;
          end else if (f.ws) begin
            state_d = ST_ATTR_SEEK;
          end else if (f.eq) begin
            equals_seen_d = 1'b1;
            state_d       = ST_ATTR_SEEK;
          end else begin
            cls = CLS_ANAME;
          end
        end
        ST_ATTR_SEEK: begin
          if (f.gt) begin
            err = ERR_NO_VALUE;
          end else if (f.dquote || f.squote) begin
            if (!equals_seen_q) begin
              err = ERR_NO_EQUALS;
            end else begin
              quote_single_d = f.squote;
              state_d        = ST_VAL_FIRST;
            end
          end else if (f.eq) begin
            equals_seen_d = 1'b1;
          end
        end
        ST_VAL_FIRST, ST_VAL: begin
          if (quote_match) begin
            state_d = ST_ATTR_WS;
          end else if (f.gt) begin
            err = ERR_QUOTE_OPEN;
          end else begin
            cls     = CLS_AVAL;
            first   = (state_q == ST_VAL_FIRST);
            state_d = ST_VAL;
          end
        end
        // text, with or without a run started
        default: begin
          if (f.lt) begin
            state_d       = ST_TAG_OPEN;
            equals_seen_d = 1'b0;
          end else begin
            cls     = CLS_TEXT;
            first   = (state_q != ST_TEXT_RUN);
            state_d = ST_TEXT_RUN;
          end
        end
      endcase

      if (done) begin
        state_d = ST_TEXT_IDLE;
      end
      // stream ends while a tag is still open
      if ((err == ERR_NONE) && item_i.last &&
          (state_d != ST_TEXT_IDLE) && (state_d != ST_TEXT_RUN)) begin
        err = ERR_EOF_IN_TAG;
      end
      if (err != ERR_NONE) begin
        sticky_d = err;
      end
    end

    // error result masks the labels
    if (err != ERR_NONE) begin
      cls   = CLS_TEXT;
      first = 1'b0;
      done  = 1'b0;
      kind  = KIND_START;
    end

    // last byte: a new stream starts clean
    if (item_i.last) begin
      state_d        = ST_TEXT_IDLE;
      quote_single_d = 1'b0;
      equals_seen_d  = 1'b0;
      tag_kind_d     = KIND_START;
      sticky_d       = ERR_NONE;
    end
  end

  // scanner state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_TEXT_IDLE;
      quote_single_q <= 1'b0;
      equals_seen_q  <= 1'b0;
      tag_kind_q     <= KIND_START;
      sticky_q       <= ERR_NONE;
      out_valid_q    <= 1'b0;
      out_byte_q     <= '0;
      out_class_q    <= CLS_TEXT;
      out_first_q    <= 1'b0;
      out_done_q     <= 1'b0;
      out_kind_q     <= KIND_START;
      out_err_q      <= ERR_NONE;
    end else begin
      out_valid_q <= pop_o | (out_valid_q & ~m_ready_i);
      if (pop_o) begin
        state_q        <= state_d;
        quote_single_q <= quote_single_d;
        equals_seen_q  <= equals_seen_d;
        tag_kind_q     <= tag_kind_d;
        sticky_q       <= sticky_d;
        out_byte_q     <= item_i.data;
        out_class_q    <= cls;
        out_first_q    <= first;
        out_done_q     <= done;
        out_kind_q     <= kind;
        out_err_q      <= err;
      end
    end
  end

  assign m_valid_o     = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign byte_class_o  = out_class_q;
  assign token_first_o = out_first_q;
  assign tag_done_o    = out_done_q;
  assign tag_kind_o    = out_kind_q;
  assign error_code_o  = out_err_q;

endmodule

@@ rtl/xml_tag_attribute_tokenizer_core.sv @@
// An accepted byte is written into the queue, then into the output register, before it reaches the output.
// Throughput: one byte per cycle while the output is taken, set by the update of the scanner state machine.
// The input queue lets input accept bytes while an output item waits to be taken.
// Reset: asynchronous, active low; clears the queue, the output register and all scanner
// state (text state, no tag open, no error).
// ----------------------------------------------------------------------------
// xml_tag_attribute_tokenizer_core
// XML tag and attribute tokenizer: labels every byte and reports tags and errors.
// ----------------------------------------------------------------------------
module xml_tag_attribute_tokenizer_core import xtt_pkg::*; #(
  parameter int QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // stream_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [8] token_first, [11:9] error_code
  output logic [5:0]  m_axis_tuser,   // [2:0] byte_class, [5:3] tag_kind
  output logic        m_axis_tlast    // tag_done
);

  tok_item_t  front_item, head_item;
  logic       push, q_full, q_valid, pop;
  logic [7:0] out_byte;
  logic [2:0] byte_class, tag_kind, error_code;
  logic       token_first, tag_done;

  // input decode
  xtt_front u_front (
    .s_valid_i (s_axis_tvalid),
    .s_data_i  (s_axis_tdata),
    .s_last_i  (s_axis_tlast),
    .s_ready_o (s_axis_tready),
    .q_full_i  (q_full),
    .push_o    (push),
    .item_o    (front_item)
  );

  // decoupling queue
  xtt_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (head_item)
  );

  // scanner and output register
  xtt_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .item_i        (head_item),
    .pop_o         (pop),
    .m_valid_o     (m_axis_tvalid),
    .m_ready_i     (m_axis_tready),
    .out_byte_o    (out_byte),
    .byte_class_o  (byte_class),
    .token_first_o (token_first),
    .tag_done_o    (tag_done),
    .tag_kind_o    (tag_kind),
    .error_code_o  (error_code)
  );

  // output packing
  assign m_axis_tdata = {4'b0000, error_code, token_first, out_byte};
  assign m_axis_tuser = {tag_kind, byte_class};
  assign m_axis_tlast = tag_done;

`ifndef SYNTH
  // an error item carries no labels
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (error_code != ERR_NONE)) |->
      ((byte_class == CLS_TEXT) && !token_first && !tag_done && (tag_kind == KIND_START)))
    else $error("error item carries labels");

  // a tag kind other than start only comes with a finished tag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !tag_done) |-> (tag_kind == KIND_START))
    else $error("tag kind without tag end");

  // a tag ends only on a closing angle bracket
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && tag_done) |-> (out_byte == CH_GT))
    else $error("tag end on a byte other than '>'");
`endif

endmodule
